// ----- hdl/tcw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS = 25;
  localparam int CELLS = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W = $clog2(COLUMNS);

  localparam logic [15:0] BLANK_CELL = 16'h0720;
  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  localparam logic [1:0] OP_PUT = 2'd0;
  localparam logic [1:0] OP_BACKSPACE = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_READ = 2'd3;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] char_code;
    logic [7:0] attribute;
    logic [10:0] cell_index;
  } cmd_t;

  typedef struct packed {
    logic [10:0] cursor_cell;
    logic scrolled;
    logic [7:0] read_char;
    logic [7:0] read_attribute;
  } res_t;

endpackage

`default_nettype wire

// ----- hdl/tcw_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input wire logic clk,
  input wire logic we,
  input wire logic [$clog2(DEPTH)-1:0] waddr,
  input wire logic [WIDTH-1:0] wdata,
  input wire logic re,
  input wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/text_console_writer.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Text console engine: a screen store of COLUMNS x ROWS cells (attribute in the
// high byte, character in the low byte) in one RAM, plus a cursor.
// Command channel cmd (cmd_valid / cmd_stall): put, backspace, clear, read.
// Result channel res (res_valid / res_stall): one result per command, holding
// the cursor after the command, the scroll flag and the read cell.
// Put, backspace and read do their RAM access at the transfer edge and load the
// result register in S_EXEC, where a waiting result can hold them; the RAM has a
// single write port and a registered read, so read data is taken in S_EXEC. A new
// command is taken only in S_IDLE, once the previous one has loaded its result.
// A put that runs past the last cell scrolls: a copy sweep through the RAM, one
// cell a cycle, then S_SCROLL_END. Clear sweeps the store blank. After reset the
// same blanking sweep runs with cmd_stall high and gives no result. A result
// waits in its register while res_stall is high; one more command is still
// taken, and it is held (cmd_stall high) until the waiting result has gone.

module text_console_writer (
  input wire logic clk,
  input wire logic rst,
  input wire logic cmd_valid,
  output logic cmd_stall,
  input wire tcw_pkg::cmd_t cmd,
  output logic res_valid,
  input wire logic res_stall,
  output tcw_pkg::res_t res
);
  import tcw_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_SCROLL = 3'd2;
  localparam logic [2:0] S_SCROLL_END = 3'd3;
  localparam logic [2:0] S_CLEAR = 3'd4;

  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] LAST_ROW_START = ADDR_W'(CELLS - COLUMNS);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);

  logic [2:0] state;
  logic [ADDR_W-1:0] ptr;
  logic emit;
  logic [ADDR_W-1:0] cursor;
  logic [COL_W-1:0] col;
  logic scrolled_flag;
  logic read_ok;
  logic wr_pend;
  logic [ADDR_W-1:0] wr_addr;
  logic wr_blank;

  logic accept;
  logic we;
  logic [ADDR_W-1:0] waddr;
  logic [15:0] wdata;
  logic re;
  logic [ADDR_W-1:0] raddr;
  logic [15:0] rdata;

  logic [ADDR_W:0] put_pos;
  logic [ADDR_W:0] nl_pos;
  logic [ADDR_W:0] adv_pos;
  logic [ADDR_W:0] scroll_src;
  logic [ADDR_W+10:0] idx_ext;
  logic idx_in_range;
  logic [ADDR_W+10:0] cur_ext;
  logic is_newline;
  logic scroll_now;

  assign accept = cmd_valid && (state == S_IDLE);
  assign cmd_stall = (state != S_IDLE);
  assign is_newline = (cmd.char_code == NEWLINE_CODE);

  assign put_pos = (ADDR_W + 1)'(cursor) + (ADDR_W + 1)'(1);
  assign nl_pos = (ADDR_W + 1)'(cursor) + (ADDR_W + 1)'(COLUMNS) - (ADDR_W + 1)'(col);
  assign adv_pos = is_newline ? nl_pos : put_pos;
  assign scroll_now = (adv_pos == (ADDR_W + 1)'(CELLS));
  assign scroll_src = (ADDR_W + 1)'(ptr) + (ADDR_W + 1)'(COLUMNS);

  assign idx_ext = (ADDR_W + 11)'(cmd.cell_index);
  assign idx_in_range = (idx_ext < (ADDR_W + 11)'(CELLS));
  assign cur_ext = (ADDR_W + 11)'(cursor);

  always_comb begin
    we = 1'b0;
    waddr = cursor;
    wdata = BLANK_CELL;
    case (state)
      S_IDLE: begin
        if (accept && cmd.operation == OP_PUT && !is_newline) begin
          we = 1'b1;
          wdata = {cmd.attribute, cmd.char_code};
        end else if (accept && cmd.operation == OP_BACKSPACE && cursor != '0) begin
          we = 1'b1;
          waddr = cursor - ADDR_W'(1);
        end
      end
      S_CLEAR: begin
        we = 1'b1;
        waddr = ptr;
      end
      S_SCROLL, S_SCROLL_END: begin
        we = wr_pend;
        waddr = wr_addr;
        wdata = wr_blank ? BLANK_CELL : rdata;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // scroll copies cell ptr + COLUMNS down to ptr (last row written blank), write lags read by one register stage
  assign re = (accept && cmd.operation == OP_READ)
    || (state == S_SCROLL && ptr < LAST_ROW_START);
  assign raddr = (state == S_SCROLL) ? scroll_src[ADDR_W-1:0] : idx_ext[ADDR_W-1:0];

  tcw_ram #(
    .WIDTH(16),
    .DEPTH(CELLS)
  ) u_screen (
    .clk(clk),
    .we(we),
    .waddr(waddr),
    .wdata(wdata),
    .re(re),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      ptr <= '0;
      emit <= 1'b0;
      cursor <= '0;
      col <= '0;
      res_valid <= 1'b0;
      wr_pend <= 1'b0;
    end else begin
      wr_pend <= (state == S_SCROLL);
      // in S_EXEC the result register is either reloaded or still stalled
      if (res_valid && !res_stall && state != S_EXEC) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            scrolled_flag <= (cmd.operation == OP_PUT) && scroll_now;
            read_ok <= (cmd.operation == OP_READ) && idx_in_range;
            case (cmd.operation)
              OP_PUT: begin
                col <= (is_newline || col == LAST_COL) ? '0 : col + COL_W'(1);
                if (scroll_now) begin
                  cursor <= LAST_ROW_START;
                  ptr <= '0;
                  state <= S_SCROLL;
                end else begin
                  cursor <= adv_pos[ADDR_W-1:0];
                  state <= S_EXEC;
                end
              end
              OP_BACKSPACE: begin
                if (cursor != '0) begin
                  cursor <= cursor - ADDR_W'(1);
                  col <= (col == '0) ? LAST_COL : col - COL_W'(1);
                end
                state <= S_EXEC;
              end
              OP_CLEAR: begin
                cursor <= '0;
                col <= '0;
                ptr <= '0;
                emit <= 1'b1;
                state <= S_CLEAR;
              end
              OP_READ: begin
                state <= S_EXEC;
              end
              default: begin
                state <= S_EXEC;
              end
            endcase
          end
        end
        S_SCROLL: begin
          wr_addr <= ptr;
          wr_blank <= (ptr >= LAST_ROW_START);
          if (ptr == LAST_CELL) begin
            state <= S_SCROLL_END;
          end else begin
            ptr <= ptr + ADDR_W'(1);
          end
        end
        S_SCROLL_END: begin
          state <= S_EXEC;
        end
        S_CLEAR: begin
          if (ptr == LAST_CELL) begin
            state <= emit ? S_EXEC : S_IDLE;
          end else begin
            ptr <= ptr + ADDR_W'(1);
          end
        end
        S_EXEC: begin
          if (!res_valid || !res_stall) begin
            res_valid <= 1'b1;
            res.cursor_cell <= cur_ext[10:0];
            res.scrolled <= scrolled_flag;
            res.read_char <= read_ok ? rdata[7:0] : 8'd0;
            res.read_attribute <= read_ok ? rdata[15:8] : 8'd0;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
